// ===== rtl/acu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acu_pkg: shared types for the interval unit
// Operation codes, result codes and controller/datapath command structs.
// ---------------------------------------------------------------------------
package acu_pkg;

  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_NORM    = 2'd1;
  localparam logic [1:0] MODE_DESCALE = 2'd2;
  localparam logic [1:0] MODE_RSVD    = 2'd3;  // unused, result all zeros

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_NORM = 2'd1;
  localparam logic [1:0] ST_BAD_SYM  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  localparam int unsigned MIN_SYMBOL_RANGE = 3;

  // datapath op selects
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;  // capture item, check
  localparam logic [2:0] OP_MUL_T   = 3'd2;  // shift-add step, product for t
  localparam logic [2:0] OP_MUL_E   = 3'd3;  // shift-add step, product for end
  localparam logic [2:0] OP_DIV     = 3'd4;  // one quotient bit
  localparam logic [2:0] OP_FINISH  = 3'd5;  // commit state, form result
  localparam logic [2:0] OP_SWAP    = 3'd6;  // latch t, set up end product

  typedef struct packed {
    logic [2:0] op;
  } acu_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       err;      // check failed at load
    logic       bypass;   // descale with all-ones range
  } acu_sts_t;

endpackage

// ===== rtl/acu_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acu_in_if / acu_out_if: valid/ready channels
// Input item and result item channels of the interval unit.
// ---------------------------------------------------------------------------
interface acu_in_if #(parameter int WORD_BITS = 64);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [WORD_BITS-1:0] symbol_base;
  logic [WORD_BITS-1:0] symbol_range;
  logic [WORD_BITS-1:0] probe_value;
  modport source (output valid, mode, symbol_base, symbol_range, probe_value, input ready);
  modport sink   (input valid, mode, symbol_base, symbol_range, probe_value, output ready);
endinterface

interface acu_out_if #(parameter int WORD_BITS = 64);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 carry;
  logic [WORD_BITS-1:0] emitted_bits;
  logic [6:0]           shift_count;
  logic [WORD_BITS-1:0] descaled_value;
  modport source (output valid, status, carry, emitted_bits, shift_count, descaled_value,
                  input ready);
  modport sink   (input valid, status, carry, emitted_bits, shift_count, descaled_value,
                  output ready);
endinterface

// ===== rtl/acu_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acu_datapath: interval registers and shared shift-add / divide unit
// Holds base and range, runs bit-serial multiply and restoring division.
// ---------------------------------------------------------------------------
module acu_datapath #(
  parameter int WORD_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  acu_pkg::acu_cmd_t         cmd,
  output acu_pkg::acu_sts_t         sts,
  input  logic [1:0]                mode,
  input  logic [WORD_BITS-1:0]      symbol_base,
  input  logic [WORD_BITS-1:0]      symbol_range,
  input  logic [WORD_BITS-1:0]      probe_value,
  output logic [1:0]                res_status,
  output logic                      res_carry,
  output logic [WORD_BITS-1:0]      res_emitted,
  output logic [6:0]                res_shift,
  output logic [WORD_BITS-1:0]      res_desc
);
  import acu_pkg::*;

  localparam int W = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] base_r, base_nxt, range_r, range_nxt;
  logic [W-1:0] a_r, a_nxt;          // multiplicand / remainder
  logic [W-1:0] b_r, b_nxt;          // multiplier bits / quotient
  logic [W:0]   acc_hi_r, acc_hi_nxt; // product high part
  logic [W-1:0] t_r, t_nxt;
  logic [1:0]   mode_r, mode_nxt;
  logic         err_r, err_nxt, byp_r, byp_nxt;
  logic [1:0]   st_r, st_nxt;

  logic [W-1:0] se, d, rsh, base_sh, range_sh;
  logic [CW-1:0] lz;
  logic         normed, sym_bad;
  logic [W:0]   rp1;     // range + 1
  logic [W+1:0] psum;
  logic [W:0]   rem2, rdiff;

  assign rp1    = {1'b0, range_r} + {{W{1'b0}}, 1'b1};
  assign normed = range_r[W-1];
  assign se     = symbol_base + symbol_range;
  assign sym_bad = (symbol_range < W'(MIN_SYMBOL_RANGE)) || (se < symbol_base);
  assign d      = probe_value - base_r;

  always_comb begin
    lz = CW'(W);
    for (int i = 0; i < W; i++) begin
      if (range_r[i]) lz = CW'(W - 1 - i);
    end
  end
  assign base_sh  = base_r << lz;
  assign rsh      = ~({W{1'b1}} << lz);
  assign range_sh = (range_r << lz) | rsh;

  // one multiply step: acc = (acc + (b0 ? rp1 : 0)) >> 1, lsb dropped, b shifts right
  assign psum  = {1'b0, acc_hi_r} + (b_r[0] ? {1'b0, rp1} : '0);
  // one divide step on remainder a, divisor rp1 (< 2^W)
  assign rem2  = {a_r, 1'b0};
  assign rdiff = rem2 - rp1;

  always_comb begin
    base_nxt = base_r; range_nxt = range_r; a_nxt = a_r; b_nxt = b_r;
    acc_hi_nxt = acc_hi_r; t_nxt = t_r; mode_nxt = mode_r; err_nxt = err_r;
    byp_nxt = byp_r; st_nxt = st_r;
    unique case (cmd.op)
      OP_LOAD: begin
        mode_nxt = mode; err_nxt = 1'b0; byp_nxt = 1'b0; st_nxt = ST_OK;
        acc_hi_nxt = '0;
        if (mode == MODE_UPDATE) begin
          b_nxt = symbol_base; a_nxt = se;
          if (!normed) begin err_nxt = 1'b1; st_nxt = ST_NOT_NORM; end
          else if (sym_bad) begin err_nxt = 1'b1; st_nxt = ST_BAD_SYM; end
        end else if (mode == MODE_DESCALE) begin
          a_nxt = d; b_nxt = '0;
          byp_nxt = &range_r;
          if (!normed) begin err_nxt = 1'b1; st_nxt = ST_NOT_NORM; end
          else if (d > range_r) begin err_nxt = 1'b1; st_nxt = ST_OUTSIDE; end
        end
      end
      OP_MUL_T, OP_MUL_E: begin
        // low product bits leave via the bottom; sticky for ceil kept in t_r[0]
        if (cmd.op == OP_MUL_T && psum[0]) t_nxt = {{(W-1){1'b0}}, 1'b1};
        acc_hi_nxt = psum[W+1:1];
        b_nxt = b_r >> 1;
      end
      OP_SWAP: begin
        // t = high + sticky; end product (se+1)*rp1 starts with rp1 preloaded
        t_nxt = acc_hi_r[W-1:0] + t_r;
        b_nxt = a_r; a_nxt = '0; acc_hi_nxt = rp1;
      end
      OP_DIV: begin
        if (rem2 >= rp1) begin
          a_nxt = rdiff[W-1:0]; b_nxt = {b_r[W-2:0], 1'b1};
        end else begin
          a_nxt = rem2[W-1:0]; b_nxt = {b_r[W-2:0], 1'b0};
        end
      end
      OP_FINISH: ;
      default: ;
    endcase
  end

  // finish terms
  logic [W-1:0] nb, nr;
  assign nb = base_r + t_r;
  assign nr = acc_hi_r[W-1:0] - t_r - {{(W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; range_r <= '1;
    end else if (cmd.op == OP_FINISH && !err_r) begin
      unique case (mode_r)
        MODE_UPDATE: begin base_r <= nb; range_r <= nr; end
        MODE_NORM: begin
          if (range_r == '0) begin base_r <= '0; range_r <= '1; end
          else begin base_r <= base_sh; range_r <= range_sh; end
        end
        default: ;
      endcase
    end
    if (cmd.op == OP_LOAD) t_r <= '0; else t_r <= t_nxt;
    a_r <= a_nxt; b_r <= b_nxt; acc_hi_r <= acc_hi_nxt;
    mode_r <= mode_nxt; err_r <= err_nxt; byp_r <= byp_nxt; st_r <= st_nxt;
    if (cmd.op == OP_FINISH) begin
      res_status <= st_r; res_carry <= 1'b0; res_emitted <= '0;
      res_shift <= '0; res_desc <= '0;
      if (!err_r) begin
        unique case (mode_r)
          MODE_UPDATE: res_carry <= (nb < t_r);
          MODE_NORM: begin
            res_emitted <= base_r;
            res_shift <= (range_r == '0) ? 7'(W) : 7'(lz);
          end
          // round up when the remainder reaches half a word
          MODE_DESCALE: res_desc <= byp_r ? a_r :
                                    (b_r + {{(W-1){1'b0}}, a_r[W-1]});
          default: ;
        endcase
      end
    end
  end

  assign sts.mode = mode_r;
  assign sts.err = err_r;
  assign sts.bypass = byp_r;
endmodule

// ===== rtl/acu_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acu_ctrl: sequencer for the interval unit
// Issues load, multiply, divide and finish commands; owns the handshake.
// ---------------------------------------------------------------------------
module acu_ctrl #(
  parameter int WORD_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output acu_pkg::acu_cmd_t cmd,
  input  acu_pkg::acu_sts_t sts
);
  import acu_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_MT = 3'd2, S_SW = 3'd3,
                         S_ME = 3'd4, S_DIV = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; state_nxt = S_CHECK; end
      S_CHECK: begin
        cnt_nxt = '0;
        if (sts.err || sts.mode == MODE_NORM || sts.bypass ||
            sts.mode == MODE_RSVD) state_nxt = S_FIN;
        else if (sts.mode == MODE_UPDATE) state_nxt = S_MT;
        else state_nxt = S_DIV;
      end
      S_MT: begin
        cmd.op = OP_MUL_T; cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(WORD_BITS - 1)) state_nxt = S_SW;
      end
      S_SW: begin cmd.op = OP_SWAP; cnt_nxt = '0; state_nxt = S_ME; end
      S_ME: begin
        cmd.op = OP_MUL_E; cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(WORD_BITS - 1)) state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.op = OP_DIV; cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(WORD_BITS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin cmd.op = OP_FINISH; state_nxt = S_OUT; end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin state_r <= S_IDLE; cnt_r <= '0; end
    else begin state_r <= state_nxt; cnt_r <= cnt_nxt; end
  end
endmodule

// ===== rtl/arith_coder_interval_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arith_coder_interval_unit: arithmetic-coder interval keeper
// Update, normalize and descale on a base/range interval.
// ---------------------------------------------------------------------------
// channel | dir | carries
// in_*    | in  | mode, symbol_base, symbol_range, probe_value
// out_*   | out | status, carry, emitted_bits, shift_count, descaled_value
//
// Steps: normalize, errors, the unused mode and the all-ones descale skip the
// serial steps; update runs two bit-serial shift-add products of (range+1),
// descale a restoring divider, one quotient bit a cycle. One item at a time.
// Reset: synchronous, base 0 and range all ones.
// Stalls: a result waits in the output register until taken.
// ---------------------------------------------------------------------------
module arith_coder_interval_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic clk,
  input  logic rst_n,
  acu_in_if.sink    in_ch,
  acu_out_if.source out_ch
);
  import acu_pkg::*;

  acu_cmd_t cmd;
  acu_sts_t sts;

  acu_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  acu_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .mode(in_ch.mode), .symbol_base(in_ch.symbol_base),
    .symbol_range(in_ch.symbol_range), .probe_value(in_ch.probe_value),
    .res_status(out_ch.status), .res_carry(out_ch.carry),
    .res_emitted(out_ch.emitted_bits), .res_shift(out_ch.shift_count),
    .res_desc(out_ch.descaled_value)
  );

  // no new item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready during result");
  // a result is followed by idle once taken
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready |=> in_ch.ready) else $error("no return to idle");
  // accepted item yields no immediate result
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !out_ch.valid) else $error("early result");
endmodule

// ===== tb/acu_tb_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acu_tb_if: testbench notes on the channel interfaces
// The channel interfaces come from the RTL file; this file holds the
// result record that the checker uses for its predictions.
// ---------------------------------------------------------------------------
package acu_tb_pkg;

  typedef struct packed {
    logic [1:0]  status;
    logic        carry;
    logic [63:0] emitted_bits;
    logic [6:0]  shift_count;
    logic [63:0] descaled_value;
  } acu_result_t;

endpackage

// ===== tb/acu_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acu_checker: interval prediction and result comparison
// Watches both channels, runs its own interval model on each accepted item
// and compares every accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module acu_checker
  import acu_pkg::*;
  import acu_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  acu_in_if  in_mon,
  acu_out_if out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);

  logic [63:0] cur_base;
  logic [63:0] cur_range;
  acu_result_t expected_q[$];

  function automatic acu_result_t interval_step(input logic [1:0] mode,
                                                input logic [63:0] sb,
                                                input logic [63:0] sr,
                                                input logic [63:0] val);
    acu_result_t r;
    logic [64:0]  se_w;
    logic [127:0] pt, pe;
    logic [63:0]  t, nb, d, q;
    logic [64:0]  rem, dv;
    logic         normed;
    int           n;
    r = '0;
    normed = cur_range[63];
    case (mode)
      MODE_UPDATE: begin
        se_w = {1'b0, sb} + {1'b0, sr};
        if (!normed) begin
          r.status = ST_NOT_NORM;
        end else if (sr < 64'(MIN_SYMBOL_RANGE) || se_w[64]) begin
          r.status = ST_BAD_SYM;
        end else begin
          pt = {64'd0, sb} * ({64'd0, cur_range} + 128'd1);
          t = pt[127:64] + {63'd0, pt[63:0] != 64'd0};
          pe = ({64'd0, se_w[63:0]} + 128'd1) * ({64'd0, cur_range} + 128'd1);
          nb = cur_base + t;
          cur_range = pe[127:64] - t - 64'd1;
          cur_base = nb;
          r.carry = nb < t;
        end
      end
      MODE_NORM: begin
        r.emitted_bits = cur_base;
        if (cur_range == 0) begin
          cur_base = '0;
          cur_range = '1;
          r.shift_count = 7'd64;
        end else begin
          n = 0;
          while (!cur_range[63 - n]) n++;
          cur_base = cur_base << n;
          cur_range = (cur_range << n) | ((64'd1 << n) - 64'd1);
          r.shift_count = n[6:0];
        end
      end
      MODE_DESCALE: begin
        d = val - cur_base;
        if (!normed) begin
          r.status = ST_NOT_NORM;
        end else if (d > cur_range) begin
          r.status = ST_OUTSIDE;
        end else if (cur_range == '1) begin
          r.descaled_value = d;
        end else begin
          // restoring division of d*2^64 by range+1
          dv = {1'b0, cur_range} + 65'd1;
          rem = {1'b0, d};
          q = '0;
          for (int i = 0; i < 64; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= dv) begin
              rem = rem - dv;
              q[0] = 1'b1;
            end
          end
          if (rem[63]) q = q + 64'd1;
          r.descaled_value = q;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    acu_result_t w;
    if (!rst_n) begin
      cur_base = '0;
      cur_range = '1;
      expected_q.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(interval_step(in_mon.mode, in_mon.symbol_base,
                                           in_mon.symbol_range, in_mon.probe_value));
      if (out_mon.valid && out_mon.ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", 64'd0, 64'd0);
        end else begin
          w = expected_q.pop_front();
          if (out_mon.status !== w.status)
            report_mismatch("status", 64'(out_mon.status), 64'(w.status));
          if (out_mon.carry !== w.carry)
            report_mismatch("carry", 64'(out_mon.carry), 64'(w.carry));
          if (out_mon.emitted_bits !== w.emitted_bits)
            report_mismatch("emitted_bits", out_mon.emitted_bits, w.emitted_bits);
          if (out_mon.shift_count !== w.shift_count)
            report_mismatch("shift_count", 64'(out_mon.shift_count), 64'(w.shift_count));
          if (out_mon.descaled_value !== w.descaled_value)
            report_mismatch("descaled_value", out_mon.descaled_value, w.descaled_value);
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: interval unit testbench top
// Drives directed and random update/normalize/descale/unused-mode items through the
// unit under shifting idle patterns and a long output hold-off; the checker
// predicts every result and the top gives the verdict.
// ---------------------------------------------------------------------------
module tb;
  import acu_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  acu_in_if  #(.WORD_BITS(64)) in_ch();
  acu_out_if #(.WORD_BITS(64)) out_ch();

  arith_coder_interval_unit #(.WORD_BITS(64)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  int fail_count, pending_count, result_count;

  acu_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  // Idle phase: 0 none, 1 sender 76%, 2 receiver 76%, 3 both 38%.
  int idle_phase = 0;
  bit hold_off = 0;     // receiver blocked for a long stretch
  int n_update, n_norm, n_descale;

  // Receiver side: random stalls, owned by this process only.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    int hold_cycles;
    if (hold_off) begin
      // long stall while the sender keeps offering; unit backs up
      out_ch.ready <= 1'b0;
      for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clk);
      hold_off = 0;
    end
    case (idle_phase)
      2:       out_ch.ready <= ($urandom_range(99) >= 76);
      3:       out_ch.ready <= ($urandom_range(99) >= 38);
      default: out_ch.ready <= 1'b1;
    endcase
  end

  // Offer one item and hold it until accepted; sender gaps come first.
  task automatic send_item(input logic [1:0] mode, input logic [63:0] sb,
                           input logic [63:0] sr, input logic [63:0] pv);
    while ((idle_phase == 1 && $urandom_range(99) < 76) ||
           (idle_phase == 3 && $urandom_range(99) < 38)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.symbol_base <= sb;
    in_ch.symbol_range <= sr;
    in_ch.probe_value <= pv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (mode)
      MODE_UPDATE:  n_update++;
      MODE_NORM:    n_norm++;
      MODE_DESCALE: n_descale++;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  // Random symbol, mostly well-formed with valid start and width, mostly large widths
  // so the interval stays wide enough to be useful.
  task automatic send_symbol();
    logic [63:0] sb, sr;
    case ($urandom_range(9))
      0: begin sb = rand64(); sr = rand64(); end  // may be invalid
      1: begin sb = '0; sr = '1; end
      default: begin
        sr = {$urandom(), $urandom()} >> $urandom_range(8);
        if (sr < 64'(MIN_SYMBOL_RANGE)) sr = 64'(MIN_SYMBOL_RANGE);
        sb = {$urandom(), $urandom()};
        if (sb > ~sr) sb = ~sr;
      end
    endcase
    send_item(MODE_UPDATE, sb, sr, rand64());
  endtask

  // Probe inside the current interval is unknown here, so aim near the
  // edges of the full word and at random; the checker sorts out status.
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50)      send_symbol();
    else if (pick < 75) send_item(MODE_NORM, rand64(), rand64(), rand64());
    else if (pick < 97) send_item(MODE_DESCALE, rand64(), rand64(), rand64());
    else                send_item(MODE_RSVD, rand64(), rand64(), rand64());
  endtask

  // Watchdog: cycles with no accept on either side.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("watchdog: no progress");
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int drain;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_UPDATE;
    in_ch.symbol_base = '0;
    in_ch.symbol_range = '0;
    in_ch.probe_value = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset interval, full-range descale, bad symbols, unused mode,
    // range collapse to zero then normalize reset, not-normalized errors.
    send_item(MODE_DESCALE, '0, '0, '0);
    send_item(MODE_DESCALE, '0, '0, '1);
    send_item(MODE_UPDATE, '0, 64'd2, '0);          // width too small
    send_item(MODE_UPDATE, '1, 64'd3, '0);          // end wraps
    send_item(MODE_UPDATE, '0, '1, '0);             // whole interval
    send_item(MODE_UPDATE, '0, 64'h8000_0000_0000_0000, '0);  // range 2^63
    send_item(MODE_UPDATE, 64'd1, 64'd3, '0);       // range drops to zero
    send_item(MODE_NORM, '0, '0, '0);               // zero range resets
    send_item(MODE_RSVD, '1, '1, '1);
    send_item(MODE_UPDATE, 64'h8000_0000_0000_0000, 64'h3, '0);
    send_item(MODE_UPDATE, '0, 64'd3, '0);          // not normalized
    send_item(MODE_DESCALE, '0, '0, '0);            // not normalized
    send_item(MODE_NORM, '0, '0, '0);
    send_item(MODE_DESCALE, '0, '0, 64'h8000_0000_0000_0000);
    send_item(MODE_DESCALE, '0, '0, '1);
    send_item(MODE_UPDATE, '1 - 64'd3, 64'd3, '0);  // top sliver, carry path
    send_item(MODE_NORM, '0, '0, '0);
    send_item(MODE_UPDATE, 64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA, '1);
    send_item(MODE_DESCALE, '1, '1, '1);
    send_item(MODE_NORM, '1, '1, '1);
    send_item(MODE_UPDATE, '0, 64'd3, '0);
    send_item(MODE_UPDATE, '0, 64'd3, '0);
    send_item(MODE_NORM, '0, '0, '0);               // small range shifted back up
    send_item(MODE_NORM, '0, '0, '0);

    // Random phases, with a long hold-off in the first one.
    for (int ph = 0; ph < 4; ph++) begin
      idle_phase = ph;
      for (int i = 0; i < 405; i++) begin
        if (ph == 0 && i == 20) hold_off = 1;
        random_item();
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    for (drain = 0; drain < 200; drain++) @(posedge clk);

    $display("covered %0d updates, %0d normalizes, %0d descales; %0d results checked",
             n_update, n_norm, n_descale, result_count);
    $display("idle phases: none, sender, receiver, both; plus one long output stall");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== arith_coder_interval_unit.f =====
rtl/acu_pkg.sv
rtl/acu_if.sv
rtl/acu_datapath.sv
rtl/acu_ctrl.sv
rtl/arith_coder_interval_unit.sv
tb/acu_tb_if.sv
tb/acu_checker.sv
tb/tb.sv
